@@ src/jct_pkg.sv @@
`default_nettype none

package jct_pkg;

    localparam int NUM_CARDS = 52;
    localparam int RANKS     = 13;

    localparam int CARD_W  = (NUM_CARDS > 2) ? $clog2(NUM_CARDS) : 1;
    localparam int CNT_W   = $clog2(NUM_CARDS + 1);
    localparam int DIVD_W  = $clog2(2 * NUM_CARDS);
    localparam int SHIFT_W = (DIVD_W > 2) ? $clog2(DIVD_W) : 1;

    // The presence scan looks at four cards in each cycle.
    localparam int CHUNK   = 4;
    localparam int NCHUNK  = (NUM_CARDS + CHUNK - 1) / CHUNK;
    localparam int CHK_W   = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;

    localparam logic [1:0] KIND_NEW_DECK  = 2'd0;
    localparam logic [1:0] KIND_COUNT_OUT = 2'd1;
    localparam logic [1:0] KIND_RETURN    = 2'd2;
    localparam logic [1:0] KIND_REMOVE    = 2'd3;

    localparam logic [1:0] ST_REMOVED     = 2'd0;
    localparam logic [1:0] ST_DONE        = 2'd1;
    localparam logic [1:0] ST_BAD_ARG     = 2'd2;
    localparam logic [1:0] ST_STACK_SHORT = 2'd3;

    typedef struct packed {
        logic [1:0] kind;
        logic [5:0] step;
        logic [5:0] count;
        logic [1:0] card_suit;
        logic [3:0] card_rank;
    } t_in;

    typedef struct packed {
        logic [1:0] status;
        logic [1:0] out_suit;
        logic [3:0] out_rank;
        logic [5:0] deck_size;
        logic [5:0] stack_size;
        logic       last;
    } t_out;

    typedef struct packed {
        logic              start;
        logic [CARD_W-1:0] k;
    } t_seek_req;

    typedef struct packed {
        logic              done;
        logic [CARD_W-1:0] card;
    } t_seek_rsp;

    typedef struct packed {
        logic              start;
        logic [DIVD_W-1:0] dividend;
        logic [CNT_W-1:0]  divisor;
    } t_mod_req;

    typedef struct packed {
        logic              done;
        logic [CARD_W-1:0] rem;
    } t_mod_rsp;

    // Suit number of a card index before it is folded into two bits.
    function automatic logic [2:0] card_group(input logic [CARD_W-1:0] c);
        logic [2:0] q;
        q = '0;
        for (int s = 1; s <= (NUM_CARDS - 1) / RANKS; s++) begin
            if (int'(c) >= s * RANKS) begin
                q = 3'(s);
            end
        end
        return q;
    endfunction

    function automatic logic [1:0] card_suit(input logic [CARD_W-1:0] c);
        logic [2:0] q;
        q = card_group(c);
        return q[1:0];
    endfunction

    function automatic logic [3:0] card_rank(input logic [CARD_W-1:0] c);
        logic [2:0] q;
        q = card_group(c);
        return 4'(int'(c) - int'(q) * RANKS);
    endfunction

endpackage

`default_nettype wire

@@ src/jct_ram.sv @@
`default_nettype none

module jct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ src/jct_seek.sv @@
`default_nettype none

// Finds the k-th present card, scanning four presence bits per cycle.
module jct_seek (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire jct_pkg::t_seek_req           i_req,
    input  wire logic [jct_pkg::NUM_CARDS-1:0] i_mask,
    output jct_pkg::t_seek_rsp                o_rsp
);

    localparam int PAD_W = jct_pkg::NCHUNK * jct_pkg::CHUNK;

    logic                         r_busy;
    logic [jct_pkg::CHK_W-1:0]    r_chunk;
    logic [jct_pkg::CARD_W-1:0]   r_k;

    logic [PAD_W-1:0]             padded;
    logic [jct_pkg::CHUNK-1:0]    bits;
    logic [2:0]                   pop;
    logic                         hit;
    logic [1:0]                   pos;

    assign padded = PAD_W'(i_mask);
    assign bits   = padded[r_chunk * jct_pkg::CHUNK +: jct_pkg::CHUNK];
    assign pop    = 3'($countones(bits));
    assign hit    = (int'(r_k) < int'(pop));

    always_comb begin
        logic [2:0] seen;
        logic       got;
        seen = '0;
        got  = 1'b0;
        pos  = '0;
        for (int j = 0; j < jct_pkg::CHUNK; j++) begin
            if (bits[j] && !got) begin
                if (seen == {1'b0, r_k[1:0]}) begin
                    pos = 2'(j);
                    got = 1'b1;
                end
                seen = seen + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
        end else if (r_busy && hit) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_k     <= i_req.k;
            r_chunk <= '0;
        end else if (r_busy && !hit) begin
            r_k     <= r_k - jct_pkg::CARD_W'(pop);
            r_chunk <= r_chunk + 1'b1;
        end
    end

    assign o_rsp.done = r_busy && hit;
    assign o_rsp.card = jct_pkg::CARD_W'({r_chunk, pos});

endmodule

`default_nettype wire

@@ src/jct_mod.sv @@
`default_nettype none

// Restoring remainder: one shifted divisor is tried per cycle.
module jct_mod (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire jct_pkg::t_mod_req i_req,
    output jct_pkg::t_mod_rsp      o_rsp
);

    localparam int WIDE_W = jct_pkg::DIVD_W + jct_pkg::CNT_W;

    logic                         r_busy;
    logic [jct_pkg::DIVD_W-1:0]   r_rem;
    logic [jct_pkg::CNT_W-1:0]    r_dvs;
    logic [jct_pkg::SHIFT_W-1:0]  r_sh;

    logic [WIDE_W-1:0]            shifted;
    logic [jct_pkg::DIVD_W-1:0]   n_rem;

    assign shifted = WIDE_W'(r_dvs) << r_sh;
    assign n_rem   = (WIDE_W'(r_rem) >= shifted)
                   ? r_rem - shifted[jct_pkg::DIVD_W-1:0] : r_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
        end else if (r_busy && r_sh == '0) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_req.dividend;
            r_dvs <= i_req.divisor;
            r_sh  <= jct_pkg::SHIFT_W'(jct_pkg::DIVD_W - 1);
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_sh  <= r_sh - 1'b1;
        end
    end

    assign o_rsp.done = r_busy && (r_sh == '0);
    assign o_rsp.rem  = jct_pkg::CARD_W'(n_rem);

endmodule

`default_nettype wire

@@ src/josephus_card_table.sv @@
`default_nettype none

// Card deck with counting-out removal and a stack of removed cards.
//
// Commands arrive as beats on the input channel (i_valid / o_ready, payload
// i_data) and results leave as beats on the output channel (o_valid /
// i_ready, payload o_data). A command is taken only while the block is idle;
// new deck, remove card and the error cases give one result, held in the
// pending register and then handed to the output register. Count out gives
// one result per removed card, or one done result when the deck is empty.
// For each card the remainder unit folds the counting index into the deck
// size, the scan walks the presence mask four cards at a time, and the
// result is handed to the output register. Return cards reads the stack
// memory one entry per cycle and then gives its single result.
//
// Reset makes all cards present and empties the stack. The stack memory has
// no clearing pass; its entries hold no meaning until count out writes them.
// A stalled receiver leaves the result in the output register; the block
// then holds its next result until the register drains, and it still takes
// the next command beat once the last result of the previous one is queued.
module josephus_card_table (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire jct_pkg::t_in  i_data,
    output logic               o_valid,
    input  wire logic          i_ready,
    output jct_pkg::t_out      o_data
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_MOD   = 6'b000010,
        S_SEEK  = 6'b000100,
        S_EMIT  = 6'b001000,
        S_POP   = 6'b010000,
        S_DRAIN = 6'b100000
    } t_state;

    t_state                          r_state, n_state;
    t_state                          r_next, n_next;
    logic [jct_pkg::NUM_CARDS-1:0]   r_deck, n_deck;
    logic [jct_pkg::CNT_W-1:0]       r_deck_cnt, n_deck_cnt;
    logic [jct_pkg::CNT_W-1:0]       r_stack_cnt, n_stack_cnt;
    logic [5:0]                      r_left, n_left;
    logic [5:0]                      r_step, n_step;
    logic [jct_pkg::CARD_W-1:0]      r_i, n_i;
    logic                            r_rd_pend, n_rd_pend;
    jct_pkg::t_out                   r_pend, n_pend;
    logic                            r_oval, n_oval;
    jct_pkg::t_out                   r_odata, n_odata;

    jct_pkg::t_seek_req              seek_req;
    jct_pkg::t_seek_rsp              seek_rsp;
    jct_pkg::t_mod_req               mod_req;
    jct_pkg::t_mod_rsp               mod_rsp;

    logic                            ram_we;
    logic [jct_pkg::CARD_W-1:0]      ram_wdata;
    logic [jct_pkg::CARD_W-1:0]      ram_rdata;
    logic [jct_pkg::CNT_W-1:0]       stack_dec;
    logic [6:0]                      rm_idx;
    logic                            accept;
    logic                            slot_free;

    assign accept    = i_valid && o_ready;
    assign slot_free = !r_oval || i_ready;
    assign stack_dec = r_stack_cnt - 1'b1;
    assign rm_idx    = 7'(i_data.card_suit) * 7'(jct_pkg::RANKS) + 7'(i_data.card_rank);

    jct_ram #(
        .WIDTH (jct_pkg::CARD_W),
        .DEPTH (jct_pkg::NUM_CARDS)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_stack_cnt[jct_pkg::CARD_W-1:0]),
        .i_wdata (ram_wdata),
        .i_raddr (stack_dec[jct_pkg::CARD_W-1:0]),
        .o_rdata (ram_rdata)
    );

    jct_seek u_seek (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (seek_req),
        .i_mask  (r_deck),
        .o_rsp   (seek_rsp)
    );

    jct_mod u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mod_req),
        .o_rsp   (mod_rsp)
    );

    always_comb begin
        logic last_card;
        n_state     = r_state;
        n_next      = r_next;
        n_deck      = r_deck;
        n_deck_cnt  = r_deck_cnt;
        n_stack_cnt = r_stack_cnt;
        n_left      = r_left;
        n_step      = r_step;
        n_i         = r_i;
        n_rd_pend   = 1'b0;
        n_pend      = r_pend;
        n_oval      = r_oval && !i_ready;
        n_odata     = r_odata;
        seek_req    = '0;
        mod_req     = '0;
        ram_we      = 1'b0;
        ram_wdata   = seek_rsp.card;
        last_card   = 1'b0;

        // A stack entry read in the previous cycle goes back into the deck
        // unless that card is already there.
        if (r_rd_pend) begin
            if (int'(ram_rdata) < jct_pkg::NUM_CARDS && !r_deck[ram_rdata]) begin
                n_deck[ram_rdata] = 1'b1;
                n_deck_cnt        = r_deck_cnt + 1'b1;
            end
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_pend.status   = jct_pkg::ST_DONE;
                    n_pend.out_suit = '0;
                    n_pend.out_rank = '0;
                    n_pend.last     = 1'b1;
                    n_next          = S_IDLE;
                    n_state         = S_EMIT;
                    unique case (i_data.kind)
                        jct_pkg::KIND_NEW_DECK: begin
                            n_deck     = '1;
                            n_deck_cnt = jct_pkg::CNT_W'(jct_pkg::NUM_CARDS);
                        end
                        jct_pkg::KIND_COUNT_OUT: begin
                            if (i_data.step == '0 || int'(i_data.step) > jct_pkg::NUM_CARDS
                                || i_data.count == '0) begin
                                n_pend.status = jct_pkg::ST_BAD_ARG;
                            end else begin
                                n_stack_cnt = '0;
                                if (r_deck_cnt != '0) begin
                                    n_left           = i_data.count;
                                    n_step           = i_data.step;
                                    mod_req.start    = 1'b1;
                                    mod_req.dividend = jct_pkg::DIVD_W'(i_data.step - 6'd1);
                                    mod_req.divisor  = r_deck_cnt;
                                    n_state          = S_MOD;
                                end
                            end
                        end
                        jct_pkg::KIND_RETURN: begin
                            if (int'(i_data.count) > int'(r_stack_cnt)) begin
                                n_pend.status = jct_pkg::ST_STACK_SHORT;
                            end else if (i_data.count != '0) begin
                                n_left  = i_data.count;
                                n_state = S_POP;
                            end
                        end
                        jct_pkg::KIND_REMOVE: begin
                            if (int'(i_data.card_rank) >= jct_pkg::RANKS
                                || int'(rm_idx) >= jct_pkg::NUM_CARDS) begin
                                n_pend.status = jct_pkg::ST_BAD_ARG;
                            end else if (r_deck[rm_idx[jct_pkg::CARD_W-1:0]]) begin
                                n_deck[rm_idx[jct_pkg::CARD_W-1:0]] = 1'b0;
                                n_deck_cnt      = r_deck_cnt - 1'b1;
                                n_pend.status   = jct_pkg::ST_REMOVED;
                                n_pend.out_suit = i_data.card_suit;
                                n_pend.out_rank = i_data.card_rank;
                            end
                        end
                    endcase
                    n_pend.deck_size  = 6'(n_deck_cnt);
                    n_pend.stack_size = 6'(n_stack_cnt);
                end
            end
            S_MOD: begin
                if (mod_rsp.done) begin
                    n_i            = mod_rsp.rem;
                    seek_req.start = 1'b1;
                    seek_req.k     = mod_rsp.rem;
                    n_state        = S_SEEK;
                end
            end
            S_SEEK: begin
                if (seek_rsp.done) begin
                    n_deck[seek_rsp.card] = 1'b0;
                    n_deck_cnt = r_deck_cnt - 1'b1;
                    if (int'(r_stack_cnt) < jct_pkg::NUM_CARDS) begin
                        ram_we      = 1'b1;
                        n_stack_cnt = r_stack_cnt + 1'b1;
                    end
                    n_left    = r_left - 6'd1;
                    last_card = (r_left == 6'd1) || (r_deck_cnt == jct_pkg::CNT_W'(1));
                    n_pend.status     = jct_pkg::ST_REMOVED;
                    n_pend.out_suit   = jct_pkg::card_suit(seek_rsp.card);
                    n_pend.out_rank   = jct_pkg::card_rank(seek_rsp.card);
                    n_pend.deck_size  = 6'(n_deck_cnt);
                    n_pend.stack_size = 6'(n_stack_cnt);
                    n_pend.last       = last_card;
                    n_next            = last_card ? S_IDLE : S_MOD;
                    n_state           = S_EMIT;
                end
            end
            S_EMIT: begin
                if (slot_free) begin
                    n_oval  = 1'b1;
                    n_odata = r_pend;
                    n_state = r_next;
                    if (r_next == S_MOD) begin
                        mod_req.start    = 1'b1;
                        mod_req.dividend = jct_pkg::DIVD_W'(r_i) + jct_pkg::DIVD_W'(r_step)
                                         - jct_pkg::DIVD_W'(1);
                        mod_req.divisor  = r_deck_cnt;
                    end
                end
            end
            S_POP: begin
                n_stack_cnt = stack_dec;
                n_left      = r_left - 6'd1;
                n_rd_pend   = 1'b1;
                if (r_left == 6'd1) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_pend.status     = jct_pkg::ST_DONE;
                n_pend.out_suit   = '0;
                n_pend.out_rank   = '0;
                n_pend.deck_size  = 6'(n_deck_cnt);
                n_pend.stack_size = 6'(n_stack_cnt);
                n_pend.last       = 1'b1;
                n_next            = S_IDLE;
                n_state           = S_EMIT;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_next      <= S_IDLE;
            r_deck      <= '1;
            r_deck_cnt  <= jct_pkg::CNT_W'(jct_pkg::NUM_CARDS);
            r_stack_cnt <= '0;
            r_left      <= '0;
            r_rd_pend   <= 1'b0;
            r_oval      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_next      <= n_next;
            r_deck      <= n_deck;
            r_deck_cnt  <= n_deck_cnt;
            r_stack_cnt <= n_stack_cnt;
            r_left      <= n_left;
            r_rd_pend   <= n_rd_pend;
            r_oval      <= n_oval;
        end
    end

    always_ff @(posedge i_clk) begin
        r_step  <= n_step;
        r_i     <= n_i;
        r_pend  <= n_pend;
        r_odata <= n_odata;
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_oval;
    assign o_data  = r_odata;

    // The stack never holds more entries than there are cards in a full deck.
    a_stack_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_stack_cnt) <= jct_pkg::NUM_CARDS)
        else $error("stack count above deck size");

    // The running card count tracks the presence mask.
    a_deck_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_deck) == int'(r_deck_cnt))
        else $error("deck count out of step with presence mask");

    // A result enters the output register only from the hand-off state.
    a_emit_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state == S_EMIT))
        else $error("result loaded outside hand-off state");

    // Every command beat moves the block out of idle.
    a_cmd_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (r_state != S_IDLE))
        else $error("command beat left the block idle");

endmodule

`default_nettype wire

@@ bench/deck_monitor.sv @@
`timescale 1ns / 1ps

// Watches both channels of the card table, keeps its own copy of the deck and
// the removed-card pile, and compares every result beat with the oldest
// outstanding prediction.
module deck_monitor
    import jct_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_ready,
    input  t_in  i_in_data,
    input  logic i_out_valid,
    input  logic i_out_ready,
    input  t_out i_out_data,
    output int   o_mismatches,
    output int   o_pending
);

    logic [NUM_CARDS-1:0] deck_mask;
    int                   pile [NUM_CARDS];
    int                   pile_depth;
    t_out                 predicted_results [$];
    int                   mismatch_total = 0;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        mismatch_total++;
    endtask

    // Card index of the k-th present card, counted from zero in card order.
    function automatic int nth_card(input int k);
        int seen;
        seen = 0;
        for (int c = 0; c < NUM_CARDS; c++) begin
            if (deck_mask[c]) begin
                if (seen == k) begin
                    return c;
                end
                seen++;
            end
        end
        return 0;
    endfunction

    task automatic push_result(input logic [1:0] status, input int card,
                               input bit has_card, input bit last_beat);
        t_out r;
        r.status     = status;
        r.out_suit   = has_card ? 2'(card / RANKS) : 2'd0;
        r.out_rank   = has_card ? 4'(card % RANKS) : 4'd0;
        r.deck_size  = 6'($countones(deck_mask));
        r.stack_size = 6'(pile_depth);
        r.last       = last_beat;
        predicted_results.push_back(r);
    endtask

    task automatic predict_command(input t_in cmd);
        int size;
        int idx;
        int left;
        int card;
        int step;
        step = int'(cmd.step);
        case (cmd.kind)
            KIND_NEW_DECK: begin
                deck_mask = '1;
                push_result(ST_DONE, 0, 1'b0, 1'b1);
            end
            KIND_COUNT_OUT: begin
                if (step < 1 || step > NUM_CARDS || cmd.count == 0) begin
                    push_result(ST_BAD_ARG, 0, 1'b0, 1'b1);
                end else begin
                    // A fresh pile is started even when the deck turns out empty.
                    pile_depth = 0;
                    size = $countones(deck_mask);
                    if (size == 0) begin
                        push_result(ST_DONE, 0, 1'b0, 1'b1);
                    end else begin
                        idx  = (step - 1) % size;
                        left = int'(cmd.count);
                        while (left > 0 && size > 0) begin
                            card = nth_card(idx);
                            deck_mask[card] = 1'b0;
                            pile[pile_depth] = card;
                            pile_depth++;
                            size--;
                            left--;
                            push_result(ST_REMOVED, card, 1'b1, left == 0 || size == 0);
                            if (size > 0) begin
                                idx = (idx + step - 1) % size;
                            end
                        end
                    end
                end
            end
            KIND_RETURN: begin
                if (int'(cmd.count) > pile_depth) begin
                    push_result(ST_STACK_SHORT, 0, 1'b0, 1'b1);
                end else begin
                    // Popped cards go back into the deck; ones already there are dropped.
                    for (int n = 0; n < int'(cmd.count); n++) begin
                        pile_depth--;
                        deck_mask[pile[pile_depth]] = 1'b1;
                    end
                    push_result(ST_DONE, 0, 1'b0, 1'b1);
                end
            end
            default: begin
                card = int'(cmd.card_suit) * RANKS + int'(cmd.card_rank);
                if (cmd.card_rank >= RANKS || card >= NUM_CARDS) begin
                    push_result(ST_BAD_ARG, 0, 1'b0, 1'b1);
                end else if (deck_mask[card]) begin
                    deck_mask[card] = 1'b0;
                    push_result(ST_REMOVED, card, 1'b1, 1'b1);
                end else begin
                    push_result(ST_DONE, 0, 1'b0, 1'b1);
                end
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            deck_mask  = '1;
            pile_depth = 0;
            predicted_results.delete();
        end else begin
            // A result beat always belongs to an earlier command, so it is
            // checked before a command beat on the same edge is predicted.
            if (i_out_valid && i_out_ready) begin
                if (predicted_results.size() == 0) begin
                    report_mismatch("result beat with nothing outstanding",
                                    int'(i_out_data), 0);
                end else begin
                    want = predicted_results.pop_front();
                    if (i_out_data.status !== want.status)
                        report_mismatch("status", i_out_data.status, want.status);
                    if (i_out_data.out_suit !== want.out_suit)
                        report_mismatch("out_suit", i_out_data.out_suit, want.out_suit);
                    if (i_out_data.out_rank !== want.out_rank)
                        report_mismatch("out_rank", i_out_data.out_rank, want.out_rank);
                    if (i_out_data.deck_size !== want.deck_size)
                        report_mismatch("deck_size", i_out_data.deck_size, want.deck_size);
                    if (i_out_data.stack_size !== want.stack_size)
                        report_mismatch("stack_size", i_out_data.stack_size, want.stack_size);
                    if (i_out_data.last !== want.last)
                        report_mismatch("last", i_out_data.last, want.last);
                end
            end
            if (i_in_valid && i_in_ready) begin
                predict_command(i_in_data);
            end
        end
        o_pending    <= predicted_results.size();
        o_mismatches <= mismatch_total;
    end

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps

// Top of the card table bench. This module only produces stimulus and gives
// the verdict; the monitor beside the block predicts and checks every result
// beat. Commands go in through a short directed list and then three random
// phases with different idle patterns on the command and result channels.
module testbench;
    import jct_pkg::*;

    // Random commands in each of the three idle phases.
    localparam int RANDOM_PER_PHASE = 130;
    // Length of the one long result stall that backs the block up.
    localparam int HOLD_CYCLES      = 300;
    // Bounds on the drain at the end of the run.
    localparam int DRAIN_LIMIT      = 100000;
    localparam int SETTLE_CYCLES    = 64;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    t_in  i_data  = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    t_out o_data;

    // Percent of cycles in which each side idles; changed between phases.
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    // Set by the stimulus process to ask the receiver for one long stall.
    bit hold_request = 1'b0;

    int mismatches;
    int pending;

    josephus_card_table i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    deck_monitor u_monitor (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_ready   (o_ready),
        .i_in_data    (i_data),
        .i_out_valid  (o_valid),
        .i_out_ready  (i_ready),
        .i_out_data   (o_data),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Safety net: a hung handshake ends the run here. The bound is far above
    // the slowest legal run, where every command removes a full deck and
    // every result beat waits out a long receiver stall.
    initial begin
        #100_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // Result side. Ready is redrawn every cycle from the current idle rate.
    // On request it drops ready for a long counted stretch, so that the
    // output register fills, the block stops taking command beats, and the
    // sender is left holding valid high.
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                i_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    function automatic t_in make_command(input logic [1:0] kind, input int step,
                                         input int count, input int suit, input int rank);
        t_in cmd;
        cmd.kind      = kind;
        cmd.step      = 6'(step);
        cmd.count     = 6'(count);
        cmd.card_suit = 2'(suit);
        cmd.card_rank = 4'(rank);
        return cmd;
    endfunction

    // Mostly well-formed commands with random content. The fields a command
    // does not use are random too, and a small share of count outs, returns and
    // removes is malformed (bad step, zero or oversized count, rank beyond the ace).
    function automatic t_in random_command();
        t_in cmd;
        int  pick;
        pick          = $urandom_range(99);
        cmd.step      = 6'($urandom_range(63));
        cmd.count     = 6'($urandom_range(63));
        cmd.card_suit = 2'($urandom_range(3));
        cmd.card_rank = 4'($urandom_range(15));
        if (pick < 8) begin
            cmd.kind = KIND_NEW_DECK;
        end else if (pick < 45) begin
            cmd.kind = KIND_COUNT_OUT;
            if ($urandom_range(9) != 0) begin
                cmd.step  = 6'($urandom_range(NUM_CARDS, 1));
                // Short count outs keep the deck alive; now and then a long one
                // sweeps most or all of it.
                cmd.count = ($urandom_range(11) == 0) ? 6'($urandom_range(63, 9))
                                                      : 6'($urandom_range(8, 1));
            end
        end else if (pick < 73) begin
            cmd.kind = KIND_RETURN;
            if ($urandom_range(7) != 0) begin
                cmd.count = 6'($urandom_range(6));
            end
        end else begin
            cmd.kind = KIND_REMOVE;
            if ($urandom_range(7) != 0) begin
                cmd.card_rank = 4'($urandom_range(RANKS - 1));
            end
        end
        return cmd;
    endfunction

    // Offers one command beat and returns on the edge that takes it. Any
    // idle gap follows right there, with junk on the payload while valid is
    // low. When no gap is drawn valid stays high, and the next call only
    // replaces the payload, so valid is never lowered and raised in one step.
    task automatic issue(input t_in cmd);
        logic [$bits(t_in)-1:0] junk;
        i_valid <= 1'b1;
        i_data  <= cmd;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        while ($urandom_range(99) < tx_idle_pct) begin
            junk = $bits(t_in)'($urandom);
            i_valid <= 1'b0;
            i_data  <= junk;
            @(posedge i_clk);
        end
    endtask

    initial begin
        int waited;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, run back to back from the reset state.
        // Remove the lowest card, then the same card again while it is absent,
        // then the highest card, then two ranks beyond the ace.
        issue(make_command(KIND_REMOVE, 0, 0, 0, 0));
        issue(make_command(KIND_REMOVE, 0, 0, 0, 0));
        issue(make_command(KIND_REMOVE, 0, 0, 3, 12));
        issue(make_command(KIND_REMOVE, 0, 0, 2, 13));
        issue(make_command(KIND_REMOVE, 63, 63, 3, 15));
        // The pile is empty after reset: returning one card comes up short,
        // and returning none changes nothing.
        issue(make_command(KIND_RETURN, 0, 1, 0, 0));
        issue(make_command(KIND_RETURN, 0, 0, 0, 0));
        issue(make_command(KIND_NEW_DECK, 0, 0, 0, 0));
        // Count out with a zero step, steps beyond the deck and a zero count.
        issue(make_command(KIND_COUNT_OUT, 0, 5, 0, 0));
        issue(make_command(KIND_COUNT_OUT, NUM_CARDS + 1, 5, 0, 0));
        issue(make_command(KIND_COUNT_OUT, 63, 63, 0, 0));
        issue(make_command(KIND_COUNT_OUT, 4, 0, 0, 0));
        // Smallest count out, undone at once.
        issue(make_command(KIND_COUNT_OUT, 1, 1, 0, 0));
        issue(make_command(KIND_RETURN, 0, 1, 0, 0));
        // Largest step with a count beyond the deck: the whole deck goes out.
        issue(make_command(KIND_COUNT_OUT, NUM_CARDS, 63, 0, 0));
        // Count out on an empty deck still starts a fresh pile, so the
        // return after it comes up short.
        issue(make_command(KIND_COUNT_OUT, 1, 1, 0, 0));
        issue(make_command(KIND_RETURN, 0, 1, 0, 0));
        issue(make_command(KIND_NEW_DECK, 0, 0, 0, 0));
        // A count equal to the deck size, then a return of the whole pile.
        issue(make_command(KIND_COUNT_OUT, 2, NUM_CARDS, 0, 0));
        issue(make_command(KIND_RETURN, 0, NUM_CARDS, 0, 0));
        // Returning cards that a new deck already put back only drops them.
        issue(make_command(KIND_COUNT_OUT, 7, 10, 0, 0));
        issue(make_command(KIND_NEW_DECK, 0, 0, 0, 0));
        issue(make_command(KIND_RETURN, 0, 4, 0, 0));
        issue(make_command(KIND_REMOVE, 0, 0, 1, 5));
        issue(make_command(KIND_RETURN, 0, 6, 0, 0));

        // Sender idles lightly while the receiver stalls most of the time.
        tx_idle_pct = 33;
        rx_idle_pct = 80;
        for (int n = 0; n < RANDOM_PER_PHASE; n++) issue(random_command());

        // The other way round.
        tx_idle_pct = 80;
        rx_idle_pct = 33;
        for (int n = 0; n < RANDOM_PER_PHASE; n++) issue(random_command());

        // No idling on either side, opened by one long receiver stall while
        // long count outs keep the command channel busy.
        tx_idle_pct  = 0;
        rx_idle_pct  = 0;
        hold_request = 1'b1;
        issue(make_command(KIND_NEW_DECK, 0, 0, 0, 0));
        issue(make_command(KIND_COUNT_OUT, 5, 20, 0, 0));
        issue(make_command(KIND_COUNT_OUT, 11, 9, 0, 0));
        issue(make_command(KIND_RETURN, 0, 3, 0, 0));
        for (int n = 0; n < RANDOM_PER_PHASE; n++) issue(random_command());

        i_valid <= 1'b0;

        // Let every predicted result come out, then give the block time to
        // show any stray extra beat.
        @(posedge i_clk);
        waited = 0;
        while (pending != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

@@ files.f @@
src/jct_pkg.sv
src/jct_ram.sv
src/jct_seek.sv
src/jct_mod.sv
src/josephus_card_table.sv
bench/deck_monitor.sv
bench/testbench.sv
